// ===== rtl/core/hfe_pkg.sv =====
// ----------------------------------------------------------------------------
// hfe_pkg: shared types and character helpers for the hex frame encoder
// Holds the command that passes from the front part to the back part, the
// nibble bit-reversal, hex digit and frame character functions.
// ----------------------------------------------------------------------------
package hfe_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned STEP_W          = 4;   // step runs 0..10, longest run is 11 characters
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [STEP_W-1:0] START_BODY   = 4'd6;
    localparam logic [STEP_W-1:0] DATA_BODY    = 4'd2;
    localparam logic [STEP_W-1:0] TRAILER_LEN  = 4'd5;

    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_B    = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_4    = 8'h34;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    // 'A' - 10, so a digit of 10..15 maps onto 'A'..'F'.
    localparam logic [BYTE_W-1:0] CHAR_HEX_BASE = 8'h37;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] value;    // length on a start, raw byte on data
        logic              trailer;  // checksum and closing text follow
        logic [BYTE_W-1:0] xsum;     // checksum to print in the trailer
    } cmd_t;

    function automatic logic [3:0] rev4(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

    function automatic logic [BYTE_W-1:0] hexc(input logic [3:0] v);
        if (v < 4'd10) begin
            return CHAR_ZERO + {4'd0, v};
        end
        return CHAR_HEX_BASE + {4'd0, v};
    endfunction

    function automatic logic [STEP_W-1:0] body_len(input cmd_t c);
        return (c.kind == KIND_START) ? START_BODY : DATA_BODY;
    endfunction

    function automatic logic [STEP_W-1:0] run_len(input cmd_t c);
        return body_len(c) + (c.trailer ? TRAILER_LEN : 4'd0);
    endfunction

    // Character at position step of the run that command c produces.
    function automatic logic [BYTE_W-1:0] frame_char(input cmd_t c,
                                                     input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] t;
        logic [BYTE_W-1:0] ch;
        t  = step - body_len(c);
        ch = CHAR_F;
        if (step < body_len(c)) begin
            if (c.kind == KIND_START) begin
                unique case (step)
                    4'd0, 4'd1: ch = CHAR_A;
                    4'd2:       ch = CHAR_B;
                    4'd3:       ch = CHAR_4;
                    4'd4:       ch = hexc(c.value[7:4]);
                    default:    ch = hexc(c.value[3:0]);
                endcase
            end else begin
                ch = (step == 4'd0) ? hexc(rev4(c.value[7:4])) : hexc(rev4(c.value[3:0]));
            end
        end else begin
            if (t == 4'd0) begin
                ch = hexc(c.xsum[7:4]);
            end else if (t == 4'd1) begin
                ch = hexc(c.xsum[3:0]);
            end
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/hfe_front.sv =====
// ----------------------------------------------------------------------------
// hfe_front: input side of the hex frame encoder
// Accepts beats, tracks the open frame and its checksum, and turns each beat
// that produces text into one command for the queue.
// ----------------------------------------------------------------------------
module hfe_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*hfe_pkg::BYTE_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        q_full,
    output logic                        q_push,
    output hfe_pkg::cmd_t               q_cmd
);
    import hfe_pkg::*;

    logic              in_frame_reg, in_frame_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    logic              accept;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] xor_upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign len      = s_tdata[BYTE_W-1:0];
    assign data     = s_tdata[2*BYTE_W-1:BYTE_W];
    assign left_dec = bytes_left_reg - 8'd1;
    assign xor_upd  = xor_reg ^ data;

    always_comb begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        q_push          = 1'b0;
        q_cmd.kind      = KIND_START;
        q_cmd.value     = len;
        q_cmd.trailer   = 1'b0;
        q_cmd.xsum      = '0;
        if (accept) begin
            if (kind_t'(s_tuser) == KIND_START) begin
                // A start always reopens, dropping any frame in progress; a zero length closes at once.
                q_push          = 1'b1;
                q_cmd.trailer   = (len == 8'd0);
                xor_next        = '0;
                in_frame_next   = (len != 8'd0);
                bytes_left_next = len;
            end else if (in_frame_reg && bytes_left_reg != 8'd0) begin
                q_push          = 1'b1;
                q_cmd.kind      = KIND_DATA;
                q_cmd.value     = data;
                q_cmd.trailer   = (left_dec == 8'd0);
                q_cmd.xsum      = xor_upd;
                xor_next        = xor_upd;
                bytes_left_next = left_dec;
                in_frame_next   = (left_dec != 8'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
        end else begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
        end
    end

endmodule

// ===== rtl/core/hfe_queue.sv =====
// ----------------------------------------------------------------------------
// hfe_queue: command queue between the front and back parts
// A small first-in first-out buffer of commands with a full flag.
// ----------------------------------------------------------------------------
module hfe_queue #(
    parameter int unsigned DEPTH = hfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output hfe_pkg::cmd_t head
);
    import hfe_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/hfe_back.sv =====
// ----------------------------------------------------------------------------
// hfe_back: character sequencer of the hex frame encoder
// Walks the run of characters for the command at the queue head, one per cycle
// unless m_ stalls, into a registered output stage; retires it on its last.
// ----------------------------------------------------------------------------
module hfe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  hfe_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hfe_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import hfe_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] char_reg;
    logic              last_reg;
    logic              done_reg;

    logic              advance;
    logic              at_end;

    assign advance = q_valid && (!valid_reg || m_tready);
    assign at_end  = (step_reg == run_len(q_cmd) - 4'd1);
    assign q_pop   = advance && at_end;

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
            step_next  = at_end ? '0 : step_reg + 4'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            char_reg <= frame_char(q_cmd, step_reg);
            last_reg <= at_end;
            // The closing 'F' is always the last character of its run.
            done_reg <= at_end && q_cmd.trailer;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

// ===== rtl/core/hex_frame_encoder_nibble_swap.sv =====
// ----------------------------------------------------------------------------
// hex_frame_encoder_nibble_swap: byte message to hex ASCII frame encoder
// Frames a byte message as uppercase hex text: header "AAB4", the length,
// two bit-reversed nibble digits per byte, then the XOR checksum and "FFF".
// ----------------------------------------------------------------------------
//
//   Channel | Direction | tdata (low bit up)              | tuser        | tlast
//   --------+-----------+---------------------------------+--------------+-----------
//   s_      | in        | frame_len[7:0], data_byte[15:8] | req_type     | unused
//   m_      | out       | out_char[7:0]                   | frame_done   | run_last
//
// A start beat yields 6 characters, or 11 for a zero length; a data beat
// yields 2, or 7 when it closes the frame. The back sequencer emits one
// character per cycle while m_ is not stalled. The front accepts a beat in
// any cycle the command queue has room, so new beats are taken while the
// back part is still emitting earlier runs. Reset is synchronous and active
// low; it closes any frame, clears the checksum and empties the queue. A
// stall on m_ holds the output register, and the queue then fills and
// deasserts s_tready.
//
module hex_frame_encoder_nibble_swap #(
    parameter int unsigned QUEUE_DEPTH = hfe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*hfe_pkg::BYTE_W-1:0]  s_tdata,   // frame_len, data_byte
    input  logic                          s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hfe_pkg::BYTE_W-1:0]    m_tdata,   // out_char
    output logic                          m_tlast,   // run_last
    output logic                          m_tuser    // frame_done
);
    import hfe_pkg::*;

    // Commands flow front -> queue -> back.
    logic q_full;
    logic q_push;
    cmd_t q_in;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    hfe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    hfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    hfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
